// ===== sv/udp_voice_packet_classifier_top_assert.svh =====
// Assertion macros used by the top level of the UDP voice packet classifier RTL.
`ifndef UDP_VOICE_PACKET_CLASSIFIER_TOP_ASSERT_SVH
`define UDP_VOICE_PACKET_CLASSIFIER_TOP_ASSERT_SVH

// Same-cycle implication checked on every clock edge outside reset.
`define UDPVC_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication checked on every clock edge outside reset.
`define UDPVC_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/udpvc_pkg.sv =====
// Shared types and constants for the UDP voice packet classifier.
package udpvc_pkg;

   localparam logic [15:0] EthHdrBytes   = 16'd14;
   localparam logic [15:0] MinFrameBytes = 16'd34;
   localparam logic [15:0] EtherTypeIpv4 = 16'h0800;
   localparam logic [7:0]  ProtoUdp      = 8'd17;
   localparam logic [15:0] CountMax      = 16'hFFFF;
   localparam logic [15:0] SignalPortRst = 16'd5060;

   typedef enum logic [1:0] {
      REG_HOST_ADDRESS    = 2'd0,
      REG_SIGNAL_PORT     = 2'd1,
      REG_MEDIA_PORT_LOW  = 2'd2,
      REG_MEDIA_PORT_HIGH = 2'd3
   } reg_index_type;

   typedef enum logic [2:0] {
      CLASS_SIGNAL    = 3'd0,
      CLASS_MEDIA     = 3'd1,
      CLASS_OTHER_UDP = 3'd2,
      CLASS_NOT_IPV4  = 3'd3,
      CLASS_NOT_UDP   = 3'd4,
      CLASS_SHORT     = 3'd5
   } class_type;

   typedef struct packed {
      logic [7:0] frame_byte;
      logic       frame_end;
   } req_type;

   typedef struct packed {
      class_type   packet_class;
      logic [15:0] source_port;
      logic [15:0] dest_port;
   } rsp_type;

   typedef struct packed {
      logic [31:0] host_address;
      logic [15:0] signal_port;
      logic [15:0] media_port_low;
      logic [15:0] media_port_high;
   } cfg_type;

   typedef struct packed {
      logic [15:0] byte_count;
      logic [15:0] ether_kind;
      logic [3:0]  header_words;
      logic [7:0]  proto_number;
      logic [31:0] from_address;
      logic [31:0] to_address;
      logic [15:0] from_port;
      logic [15:0] to_port;
   } frame_type;

endpackage

// ===== sv/udpvc_csr.sv =====
// Configuration registers of the UDP voice packet classifier.
module udpvc_csr
   import udpvc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          csr_valid,
   output logic          csr_ready,
   input  reg_index_type csr_index,
   input  logic [31:0]   csr_wdata,
   output cfg_type       cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            REG_HOST_ADDRESS:    cfg_in.host_address    = csr_wdata;
            REG_SIGNAL_PORT:     cfg_in.signal_port     = csr_wdata[15:0];
            REG_MEDIA_PORT_LOW:  cfg_in.media_port_low  = csr_wdata[15:0];
            REG_MEDIA_PORT_HIGH: cfg_in.media_port_high = csr_wdata[15:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.host_address    <= '0;
         cfg_ff.signal_port     <= SignalPortRst;
         cfg_ff.media_port_low  <= '0;
         cfg_ff.media_port_high <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== sv/udpvc_capture.sv =====
// Per-frame field capture and byte counting of the UDP voice packet classifier.
module udpvc_capture
   import udpvc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       advance,
   input  req_type    req,
   output frame_type frame
);

   frame_type   state_ff;
   frame_type   state_in;
   logic [15:0] pos;
   logic [3:0]  words;
   logic [15:0] port_at;
   logic [15:0] port_off;
   logic        in_ports;

   assign pos      = state_ff.byte_count;
   assign words    = (pos == 16'd14) ? req.frame_byte[3:0] : state_ff.header_words;
   assign port_at  = EthHdrBytes + {10'd0, words, 2'b00};
   assign port_off = pos - port_at;
   assign in_ports = (pos >= port_at) && (port_off < 16'd4);

   always_comb begin
      state_in = state_ff;
      state_in.byte_count = (pos == CountMax) ? CountMax : pos + 16'd1;
      if ((pos == 16'd12) || (pos == 16'd13)) begin
         state_in.ether_kind = {state_ff.ether_kind[7:0], req.frame_byte};
      end
      if (pos == 16'd14) begin
         state_in.header_words = req.frame_byte[3:0];
      end
      if (pos == 16'd23) begin
         state_in.proto_number = req.frame_byte;
      end
      if ((pos >= 16'd26) && (pos <= 16'd29)) begin
         state_in.from_address = {state_ff.from_address[23:0], req.frame_byte};
      end
      if ((pos >= 16'd30) && (pos <= 16'd33)) begin
         state_in.to_address = {state_ff.to_address[23:0], req.frame_byte};
      end
      if (in_ports) begin
         if (!port_off[1]) begin
            state_in.from_port = {state_ff.from_port[7:0], req.frame_byte};
         end else begin
            state_in.to_port = {state_ff.to_port[7:0], req.frame_byte};
         end
      end
   end

   assign frame = state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (advance) begin
         if (req.frame_end) begin
            state_ff <= '0;
         end else begin
            state_ff <= state_in;
         end
      end
   end

endmodule

// ===== sv/udpvc_classify.sv =====
// Frame classification from the captured fields of the UDP voice packet classifier.
module udpvc_classify
   import udpvc_pkg::*;
(
   input  frame_type frame,
   input  cfg_type   cfg,
   output rsp_type   rsp
);

   logic [15:0] min_len;
   logic        sig_from;
   logic        sig_to;
   logic        media;
   class_type   cls;

   assign min_len  = MinFrameBytes + {10'd0, frame.header_words, 2'b00};
   assign sig_from = (frame.from_address == cfg.host_address) &&
                     (frame.from_port == cfg.signal_port);
   assign sig_to   = (frame.to_address == cfg.host_address) &&
                     (frame.to_port == cfg.signal_port);
   assign media    = (frame.from_port >= cfg.media_port_low) &&
                     (frame.from_port <= cfg.media_port_high);

   always_comb begin
      priority if (frame.byte_count < MinFrameBytes) begin
         cls = CLASS_SHORT;
      end else if (frame.ether_kind != EtherTypeIpv4) begin
         cls = CLASS_NOT_IPV4;
      end else if (frame.byte_count < min_len) begin
         cls = CLASS_SHORT;
      end else if (frame.proto_number != ProtoUdp) begin
         cls = CLASS_NOT_UDP;
      end else if (sig_from || sig_to) begin
         cls = CLASS_SIGNAL;
      end else if (media) begin
         cls = CLASS_MEDIA;
      end else begin
         cls = CLASS_OTHER_UDP;
      end
   end

   always_comb begin
      rsp.packet_class = cls;
      if ((cls == CLASS_SHORT) || (cls == CLASS_NOT_IPV4)) begin
         rsp.source_port = '0;
         rsp.dest_port   = '0;
      end else begin
         rsp.source_port = frame.from_port;
         rsp.dest_port   = frame.to_port;
      end
   end

endmodule

// ===== sv/udp_voice_packet_classifier_top.sv =====
// Top level of the UDP voice packet classifier.
// A request is registered in the capture stage; a result is registered as its last byte leaves it.
// Throughput: one frame byte per cycle unless a last byte waits on a stalled result.
// A stalled result holds only requests that carry a last byte; other bytes keep flowing.
// Reset is synchronous: it clears frame state, empties both stages and restores registers.
module udp_voice_packet_classifier_top
   import udpvc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  req_type       req_data,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output rsp_type       rsp_data,
   input  logic          csr_valid,
   output logic          csr_ready,
   input  reg_index_type csr_index,
   input  logic [31:0]   csr_wdata
);

`include "udp_voice_packet_classifier_top_assert.svh"

   logic      s1_valid_ff;
   req_type   s1_data_ff;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   rsp_type   rsp_data_ff;
   rsp_type   rsp_next;
   frame_type frame;
   cfg_type   cfg;
   logic      out_free;
   logic      s1_go;
   logic      s1_load;
   logic      end_go;
   logic      end_blocked;
   logic      rsp_class_ok;
   logic      rsp_ports_ok;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign s1_go     = s1_valid_ff && (!s1_data_ff.frame_end || out_free);
   assign s1_load   = !s1_valid_ff || s1_go;
   assign req_stall = !s1_load;
   assign end_go    = s1_go && s1_data_ff.frame_end;

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_data     = rsp_data_ff;
   assign rsp_valid_in = end_go || (rsp_valid_ff && rsp_stall);

   assign end_blocked  = s1_valid_ff && s1_data_ff.frame_end && rsp_valid_ff && rsp_stall;
   assign rsp_class_ok = (rsp_data_ff.packet_class <= CLASS_SHORT);
   assign rsp_ports_ok = ((rsp_data_ff.packet_class != CLASS_SHORT) &&
                          (rsp_data_ff.packet_class != CLASS_NOT_IPV4)) ||
                         ((rsp_data_ff.source_port == 16'd0) &&
                          (rsp_data_ff.dest_port == 16'd0));

   udpvc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   udpvc_capture u_capture (
      .clock   (clock),
      .reset   (reset),
      .advance (s1_go),
      .req     (s1_data_ff),
      .frame   (frame)
   );

   udpvc_classify u_classify (
      .frame (frame),
      .cfg   (cfg),
      .rsp   (rsp_next)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (s1_load) begin
            s1_valid_ff <= req_valid;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_load && req_valid) begin
         s1_data_ff <= req_data;
      end
      if (end_go) begin
         rsp_data_ff <= rsp_next;
      end
   end

   `UDPVC_ASSERT_SAME(a_class_range, rsp_valid_ff, rsp_class_ok, "result class out of range")
   `UDPVC_ASSERT_SAME(a_ports_zero, rsp_valid_ff, rsp_ports_ok, "ports not cleared")
   `UDPVC_ASSERT_SAME(a_stall_cause, req_stall, end_blocked, "stall without a blocked last byte")
   `UDPVC_ASSERT_NEXT(a_end_gives_result, end_go, rsp_valid_ff, "last byte gave no result")

endmodule
